FILE: hdl/scan_code_set1_to_ascii_unit_macros.svh
// assertion macros for the scan code set 1 decoder
`ifndef SCAN_CODE_SET1_TO_ASCII_UNIT_MACROS_SVH
`define SCAN_CODE_SET1_TO_ASCII_UNIT_MACROS_SVH

// same-cycle implication under reset
`define SC1_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define SC1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sc1asc_pkg.sv
// types, constants and key tables for the scan code set 1 decoder
package sc1asc_pkg;

    localparam int TABLE_ENTRIES = 89;

    localparam logic [7:0] CODE_PAUSE_PREFIX = 8'hE1;
    localparam logic [7:0] CODE_EXT_PREFIX   = 8'hE0;
    localparam logic [7:0] PAUSE_KEY         = 8'hA0;
    localparam logic [7:0] NO_KEY            = 8'h00;
    localparam logic [7:0] CHAR_LOWER_A      = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z      = 8'h7A;

    localparam int RELEASE_BIT = 7;

    localparam logic [6:0] ROW_LSHIFT        = 7'd42;
    localparam logic [6:0] ROW_RSHIFT        = 7'd54;
    localparam logic [6:0] ROW_CAPS          = 7'd58;
    localparam logic [6:0] ROW_NUM           = 7'd69;
    localparam logic [6:0] ROW_SCROLL        = 7'd70;
    localparam logic [6:0] ROW_SYMBOL_FIRST  = 7'd2;
    localparam logic [6:0] ROW_SYMBOL_LAST   = 7'd53;
    localparam logic [6:0] ROW_KEYPAD_FIRST  = 7'd71;
    localparam logic [6:0] ROW_KEYPAD_LAST   = 7'd83;

    localparam logic [2:0] PAUSE_SKIP_RESET  = 3'd2;

    localparam logic [7:0] NORMAL_CODE [TABLE_ENTRIES] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h81,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h82, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h83, 8'h2A, 8'h85, 8'h20, 8'h86, 8'h87,
        8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
        8'h92, 8'h93, 8'h94, 8'h95, 8'h2D, 8'h96, 8'h97, 8'h98, 8'h2B, 8'h99,
        8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h00, 8'h00, 8'h00, 8'h9E, 8'h9F
    };

    localparam logic [7:0] COMBINED_CODE [TABLE_ENTRIES] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h81,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h82, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h83, 8'h2A, 8'h85, 8'h20, 8'h86, 8'h87,
        8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
        8'h92, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h9E, 8'h9F
    };

    typedef struct packed {
        logic       shift_held;
        logic       caps_on;
        logic       num_on;
        logic       scroll_on;
        logic       prefix_pending;
        logic [2:0] skip_left;
    } kbd_state_t;

    // first member sits in the top bits
    typedef struct packed {
        logic       led_update;
        logic       scroll_led;
        logic       num_led;
        logic       caps_led;
        logic       extended_key;
        logic       pressed;
        logic [7:0] raw_code;
        logic [7:0] key_code;
    } key_result_t;

    function automatic logic [7:0] row_code(input logic [6:0] row, input logic combined);
        logic [7:0] code;
        code = NO_KEY;
        if (int'(row) < TABLE_ENTRIES)
        begin
            code = combined ? COMBINED_CODE[row] : NORMAL_CODE[row];
        end
        return code;
    endfunction

endpackage

FILE: hdl/sc1asc_decode.sv
// decode of one scan code byte: key lookup, shift, lock, prefix and pause skip tracking
module sc1asc_decode
    import sc1asc_pkg::*;
(
    input  logic [7:0]  scan_code,
    input  kbd_state_t  state,
    input  logic [2:0]  pause_skip_count,
    output kbd_state_t  state_next,
    output key_result_t result,
    output logic        result_valid
);

    logic [6:0] row;
    logic       down;
    logic [7:0] normal;
    logic       is_letter;
    logic       combined;

    assign row    = scan_code[6:0];
    assign down   = ~scan_code[RELEASE_BIT];
    assign normal = row_code(row, 1'b0);
    assign is_letter = (normal >= CHAR_LOWER_A) && (normal <= CHAR_LOWER_Z);

    always_comb
    begin
        priority if (is_letter)
            combined = state.shift_held ^ state.caps_on;
        else if (row >= ROW_SYMBOL_FIRST && row <= ROW_SYMBOL_LAST)
            combined = state.shift_held;
        else if (row >= ROW_KEYPAD_FIRST && row <= ROW_KEYPAD_LAST && !state.prefix_pending)
            combined = state.num_on;
        else
            combined = 1'b0;
    end

    always_comb
    begin
        state_next   = state;
        result_valid = 1'b0;
        result       = '0;
        result.raw_code = scan_code;

        priority if (state.skip_left != 3'd0)
        begin
            // swallowing the tail of a pause sequence
            state_next.skip_left = state.skip_left - 3'd1;
        end
        else if (scan_code == CODE_PAUSE_PREFIX)
        begin
            state_next.skip_left = pause_skip_count;
            result_valid      = 1'b1;
            result.key_code   = PAUSE_KEY;
            result.pressed    = 1'b1;
            result.caps_led   = state.caps_on;
            result.num_led    = state.num_on;
            result.scroll_led = state.scroll_on;
        end
        else if (scan_code == CODE_EXT_PREFIX)
        begin
            state_next.prefix_pending = 1'b1;
        end
        else
        begin
            result_valid        = 1'b1;
            result.key_code     = row_code(row, combined);
            result.pressed      = down;
            result.extended_key = state.prefix_pending;
            state_next.prefix_pending = 1'b0;

            priority if (row == ROW_LSHIFT || row == ROW_RSHIFT)
                state_next.shift_held = down;
            else if (down && row == ROW_CAPS)
            begin
                state_next.caps_on = ~state.caps_on;
                result.led_update  = 1'b1;
            end
            else if (down && row == ROW_NUM)
            begin
                state_next.num_on = ~state.num_on;
                result.led_update = 1'b1;
            end
            else if (down && row == ROW_SCROLL)
            begin
                state_next.scroll_on = ~state.scroll_on;
                result.led_update    = 1'b1;
            end
            else
            begin
                state_next.shift_held = state.shift_held;
            end

            result.caps_led   = state_next.caps_on;
            result.num_led    = state_next.num_on;
            result.scroll_led = state_next.scroll_on;
        end
    end

endmodule

FILE: hdl/scan_code_set1_to_ascii_unit.sv
// top level of the scan code set 1 to ascii decoder
// Usage:
//   s_tvalid/s_tready/s_tdata carry one raw set 1 scan code byte per word.
//   m_tvalid/m_tready/m_tdata carry one decoded key word; prefix bytes
//   (0xE0) and the bytes swallowed after a pause prefix give no word.
//   cfg_we/cfg_wdata write the pause skip count (reset value 2); write it
//   only while no words are in flight.
// Timing:
//   a byte is held in an input register, decoded combinationally and lands in
//   the output register, which drives m_tdata; a stall can hold it in either.
//   One byte per cycle is taken while m_tready stays high; the single decode stage sets that figure.
// Reset:
//   rst_n clears shift, lock, prefix and skip state and empties both
//   registers; the skip count returns to 2.
// Stall:
//   while m_tready is low the output word holds and the input register
//   still takes one more byte, then s_tready drops until the output drains.
module scan_code_set1_to_ascii_unit
    import sc1asc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,    // pause_skip_count

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // scan_code[7:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata       // key_code[7:0], raw_code[15:8], pressed[16],
                                      // extended_key[17], caps_led[18], num_led[19],
                                      // scroll_led[20], led_update[21], zero[23:22]
);

    `include "scan_code_set1_to_ascii_unit_macros.svh"

    logic [2:0]  pause_skip_count_reg;
    logic        in_valid_reg;
    logic [7:0]  in_code_reg;
    kbd_state_t  state_reg;
    kbd_state_t  state_next;
    logic        out_valid_reg;
    key_result_t out_result_reg;

    key_result_t result;
    logic        result_valid;
    logic        in_advance;

    sc1asc_decode u_decode (
        .scan_code        (in_code_reg),
        .state            (state_reg),
        .pause_skip_count (pause_skip_count_reg),
        .state_next       (state_next),
        .result           (result),
        .result_valid     (result_valid)
    );

    assign in_advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || in_advance;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {2'b00, out_result_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pause_skip_count_reg <= PAUSE_SKIP_RESET;
        end
        else if (cfg_we)
        begin
            pause_skip_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (in_advance)
                in_valid_reg <= 1'b0;

            if (in_advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= result_valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_code_reg <= s_tdata;
        if (in_advance)
            out_result_reg <= result;
    end

    `SC1_ASSERT_NEXT(a_skip_countdown, clk, rst_n,
        in_advance && (state_reg.skip_left != 3'd0),
        state_reg.skip_left == 3'($past(state_reg.skip_left) - 3'd1),
        "skip countdown did not step by one")
    `SC1_ASSERT_NEXT(a_input_held, clk, rst_n,
        in_valid_reg && !in_advance,
        in_valid_reg && (in_code_reg == $past(in_code_reg)),
        "stalled input byte was lost")
    `SC1_ASSERT_SAME(a_led_on_press, clk, rst_n,
        out_valid_reg && out_result_reg.led_update,
        out_result_reg.pressed,
        "led update on a release")
    `SC1_ASSERT_SAME(a_pause_word, clk, rst_n,
        out_valid_reg && (out_result_reg.raw_code == CODE_PAUSE_PREFIX),
        (out_result_reg.key_code == PAUSE_KEY) && !out_result_reg.led_update,
        "pause prefix decoded wrongly")

endmodule
